// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ZSN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ZSN_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/zsn_pkg.sv -----
// ----------------------------------------------------------------------------
// zsn_pkg
// Types and constants shared by the z-score normalizer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package zsn_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STATUS_W = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [STATUS_W-1:0]        status_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_ZERO_DEV = 2'd1;
   localparam status_type STATUS_DROPPED  = 2'd2;

   // Upper bound of the normalizing shift count.
   localparam int H_MAX = 24;
   // Number of quotient bits that the per-sample division resolves.
   localparam int QUOT_W = 17;

endpackage

`default_nettype wire

// ----- hw/rtl/zscore_normalizer_top.sv -----
// ----------------------------------------------------------------------------
// zscore_normalizer_top
// Buffers a set of Q8.8 samples, then emits each one standardized by the
// set's mean and population standard deviation.
// ----------------------------------------------------------------------------
//
//  Channel | Ports         | Payload
//  --------+---------------+-----------------------------------------------
//  input   | req_t*        | tdata: sample[15:0]; tlast: final_sample
//  output  | rsp_t*        | tdata: zscore[15:0]; tlast: end_of_set;
//          |               | tuser: status[1:0]
//
//  Samples load at one per cycle into a sample memory with one write port
//  and one registered read port.
//  After the final sample, statistics are computed in turn (sum of squares
//  over the memory, shift-add multiply, normalize of up to 24 steps and
//  32-step integer square root). Each result then comes from the 17-step
//  restoring divider, which is skipped when the quotient saturates.
//  Reset is synchronous; req_tready is high only while samples load, and a
//  stalled output holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module zscore_normalizer_top #(
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [zsn_pkg::SAMPLE_W-1:0]  req_tdata,   // [15:0] sample
   input  wire logic                          req_tlast,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [zsn_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [15:0] zscore
   output logic                               rsp_tlast,
   output logic [zsn_pkg::STATUS_W-1:0]       rsp_tuser    // [1:0] status
);
   import zsn_pkg::*;

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int SW   = SAMPLE_W + CW;
   localparam int QW   = 2 * SAMPLE_W - 1 + CW;
   localparam int NUMW = CW + SAMPLE_W + 2;

   localparam logic [3:0] S_LOAD    = 4'd0;
   localparam logic [3:0] S_SQ_RD   = 4'd1;
   localparam logic [3:0] S_SQ_MUL  = 4'd2;
   localparam logic [3:0] S_SQ_ACC  = 4'd3;
   localparam logic [3:0] S_NQ      = 4'd4;
   localparam logic [3:0] S_VAR     = 4'd5;
   localparam logic [3:0] S_NORM    = 4'd6;
   localparam logic [3:0] S_SQRT    = 4'd7;
   localparam logic [3:0] S_EM_RD   = 4'd8;
   localparam logic [3:0] S_EM_NUM  = 4'd9;
   localparam logic [3:0] S_EM_PREP = 4'd10;
   localparam logic [3:0] S_EM_SAT  = 4'd11;
   localparam logic [3:0] S_EM_DIV  = 4'd12;
   localparam logic [3:0] S_EM_OUT  = 4'd13;
   localparam logic [3:0] S_ERR     = 4'd14;

   logic [3:0]             state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic signed [SW-1:0]   sum_ff, sum_in;
   logic                   ovf_ff, ovf_in;
   logic [QW-1:0]          qacc_ff, qacc_in;
   logic [31:0]            prod_ff, prod_in;
   logic [63:0]            mcand_ff, mcand_in;
   logic [CW-1:0]          mplier_ff, mplier_in;
   logic [63:0]            nq_ff, nq_in;
   logic [63:0]            ss_ff, ss_in;
   logic [63:0]            v_ff, v_in;
   logic [4:0]             h_ff, h_in;
   logic [63:0]            r_ff, r_in;
   logic [63:0]            bit_ff, bit_in;
   logic signed [NUMW-1:0] num_ff, num_in;
   logic                   neg_ff, neg_in;
   logic [63:0]            dvd_ff, dvd_in;
   logic [4:0]             k_ff, k_in;
   logic [QUOT_W-1:0]      quo_ff, quo_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sample_type             rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;
   status_type             rsp_user_ff, rsp_user_in;

   logic [SAMPLE_W-1:0]    mem [MAX_SAMPLES];
   sample_type             rd_data_ff;
   logic                   wr_en;

   logic signed [31:0]     sq_w;
   logic signed [2*SW-1:0] ss_w;
   logic signed [63:0]     v_w;
   logic signed [NUMW-1:0] num_w;
   logic [NUMW-1:0]        mag_w;
   logic [63:0]            root_try;
   logic [63:0]            dk_w;
   logic                   out_free;
   logic                   last_item;
   sample_type             z_w;

   assign req_tready = (state_ff == S_LOAD);
   assign wr_en      = req_tvalid && req_tready && (cnt_ff < CW'(MAX_SAMPLES));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_item  = (idx_ff + CW'(1)) == cnt_ff;

   assign sq_w     = rd_data_ff * rd_data_ff;
   assign ss_w     = sum_ff * sum_ff;
   assign v_w      = $signed(nq_ff) - $signed(ss_ff);
   assign num_w    = $signed({1'b0, cnt_ff}) * rd_data_ff - sum_ff;
   assign mag_w    = neg_ff ? NUMW'(-num_ff) : NUMW'(num_ff);
   assign root_try = r_ff + bit_ff;
   assign dk_w     = r_ff << ({1'b0, k_ff} + 6'd1);

   // Round-half-away quotient magnitude, then sign and saturate.
   always_comb begin
      if (neg_ff) begin
         z_w = (quo_ff > QUOT_W'(32768)) ? 16'sh8000 : sample_type'(-quo_ff[15:0]);
      end else begin
         z_w = (quo_ff > QUOT_W'(32767)) ? 16'sh7fff : sample_type'(quo_ff[15:0]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      qacc_in      = qacc_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      nq_in        = nq_ff;
      ss_in        = ss_ff;
      v_in         = v_ff;
      h_in         = h_ff;
      r_in         = r_ff;
      bit_in       = bit_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      k_in         = k_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               if (wr_en) begin
                  cnt_in = cnt_ff + CW'(1);
                  sum_in = sum_ff + SW'($signed(req_tdata));
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  idx_in   = '0;
                  qacc_in  = '0;
                  state_in = S_SQ_RD;
               end
            end
         end
         S_SQ_RD: begin
            state_in = S_SQ_MUL;
         end
         S_SQ_MUL: begin
            prod_in  = 32'(sq_w);
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            qacc_in = qacc_ff + QW'(prod_ff);
            idx_in  = idx_ff + CW'(1);
            if (last_item) begin
               mcand_in  = 64'(qacc_ff + QW'(prod_ff));
               mplier_in = cnt_ff;
               nq_in     = '0;
               ss_in     = 64'(ss_w);
               state_in  = S_NQ;
            end else begin
               state_in = S_SQ_RD;
            end
         end
         S_NQ: begin
            if (mplier_ff == '0) begin
               state_in = S_VAR;
            end else begin
               if (mplier_ff[0]) begin
                  nq_in = nq_ff + mcand_ff;
               end
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         S_VAR: begin
            v_in = 64'(v_w);
            h_in = '0;
            if (v_w[63] || v_w == 64'sd0) begin
               state_in = S_ERR;
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (h_ff < 5'(H_MAX) && v_ff[63:60] == 4'd0) begin
               v_in = v_ff << 2;
               h_in = h_ff + 5'd1;
            end else begin
               r_in     = '0;
               bit_in   = 64'd1 << 62;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (bit_ff == '0) begin
               idx_in   = '0;
               state_in = S_EM_RD;
            end else begin
               if (v_ff >= root_try) begin
                  v_in = v_ff - root_try;
                  r_in = (r_ff >> 1) + bit_ff;
               end else begin
                  r_in = r_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         S_EM_RD: begin
            state_in = S_EM_NUM;
         end
         S_EM_NUM: begin
            num_in   = num_w;
            neg_in   = num_w[NUMW-1];
            state_in = S_EM_PREP;
         end
         S_EM_PREP: begin
            dvd_in   = (64'(mag_w) << ({1'b0, h_ff} + 6'd9)) + r_ff;
            state_in = S_EM_SAT;
         end
         S_EM_SAT: begin
            // A quotient of 2^17 or more saturates either way.
            if (dvd_ff >= (r_ff << (QUOT_W + 1))) begin
               quo_in   = '1;
               state_in = S_EM_OUT;
            end else begin
               quo_in   = '0;
               k_in     = 5'(QUOT_W - 1);
               state_in = S_EM_DIV;
            end
         end
         S_EM_DIV: begin
            if (dvd_ff >= dk_w) begin
               dvd_in = dvd_ff - dk_w;
               quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
            end
            if (k_ff == '0) begin
               state_in = S_EM_OUT;
            end else begin
               k_in = k_ff - 5'd1;
            end
         end
         S_EM_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = z_w;
               rsp_last_in  = last_item;
               rsp_user_in  = ovf_ff ? STATUS_DROPPED : STATUS_OK;
               idx_in       = idx_ff + CW'(1);
               if (last_item) begin
                  cnt_in   = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_EM_RD;
               end
            end
         end
         S_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_user_in  = STATUS_ZERO_DEV;
               cnt_in       = '0;
               sum_in       = '0;
               ovf_in       = 1'b0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      qacc_ff     <= qacc_in;
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      nq_ff       <= nq_in;
      ss_ff       <= ss_in;
      v_ff        <= v_in;
      h_ff        <= h_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      dvd_ff      <= dvd_in;
      k_ff        <= k_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Sample memory: one write port while loading, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff[AW-1:0]] <= req_tdata;
      end
      rd_data_ff <= sample_type'(mem[idx_ff[AW-1:0]]);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/zsn_checker.sv -----
// ----------------------------------------------------------------------------
// zsn_checker
// Port-level checks on the result stream of the z-score normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module zsn_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [zsn_pkg::SAMPLE_W-1:0] rsp_tdata,
   input wire logic                         rsp_tlast,
   input wire logic [zsn_pkg::STATUS_W-1:0] rsp_tuser
);
   import zsn_pkg::*;

   // A stalled result must stay put until the transfer completes.
   `ZSN_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

   `ZSN_ASSERT(a_status_code, rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_ZERO_DEV || rsp_tuser == STATUS_DROPPED), "unknown status code")

   // The zero-deviation result is a lone, closing zero.
   `ZSN_ASSERT(a_zero_dev, rsp_tvalid && rsp_tuser == STATUS_ZERO_DEV |-> rsp_tlast && rsp_tdata == '0, "bad zero-deviation result")

   `ZSN_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind zscore_normalizer_top zsn_checker u_zsn_checker (.*);

`default_nettype wire

// ----- dv/zsn_checker.sv -----
// ----------------------------------------------------------------------------
// zsn_scoreboard
// Watches both stream channels of the z-score normalizer, predicts the
// standardized results of every sample set and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module zsn_scoreboard #(
   parameter int MAX_SAMPLES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic [zsn_pkg::SAMPLE_W-1:0]  req_tdata,
   input  wire logic                          req_tlast,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [zsn_pkg::SAMPLE_W-1:0]  rsp_tdata,
   input  wire logic                          rsp_tlast,
   input  wire logic [zsn_pkg::STATUS_W-1:0]  rsp_tuser,
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 result_count
);
   import zsn_pkg::*;

   typedef struct packed {
      sample_type zscore;
      logic       end_of_set;
      status_type status;
   } zresult_type;

   zresult_type expected_results[$];
   sample_type  set_samples[MAX_SAMPLES];
   int          set_count;
   longint      set_sum;
   logic        dropped_seen;

   assign pending_count = expected_results.size();

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitpos;
      root   = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v    -= root + bitpos;
            root  = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   // Rounded quotient num * 2^shift / root, halves away from zero, saturated.
   function automatic sample_type scaled_div(longint num, int shift, longint unsigned root);
      longint unsigned mag, quo;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      quo = ((mag << (shift + 1)) + root) / (root << 1);
      if (num < 0) return (quo > 32768) ? sample_type'(-32768) : sample_type'(-longint'(quo));
      return (quo > 32767) ? sample_type'(32767) : sample_type'(quo);
   endfunction

   task automatic predict_set();
      longint          sq_sum, variance;
      longint unsigned uvar, root;
      int              hshift;
      zresult_type     res;
      sq_sum = 0;
      hshift = 0;
      for (int i = 0; i < set_count; i++)
         sq_sum += longint'(set_samples[i]) * longint'(set_samples[i]);
      variance = longint'(set_count) * sq_sum - set_sum * set_sum;
      if (variance <= 0) begin
         res.zscore     = '0;
         res.end_of_set = 1'b1;
         res.status     = STATUS_ZERO_DEV;
         expected_results = {expected_results, res};
      end else begin
         uvar = variance;
         while (hshift < H_MAX &&
                ((uvar << (2 * (hshift + 1))) >> (2 * (hshift + 1))) == uvar &&
                (uvar << (2 * (hshift + 1))) < (64'd1 << 62))
            hshift++;
         root = int_sqrt(uvar << (2 * hshift));
         for (int i = 0; i < set_count; i++) begin
            res.zscore     = scaled_div(longint'(set_count) * longint'(set_samples[i]) - set_sum,
                                        8 + hshift, root);
            res.end_of_set = (i + 1 == set_count);
            res.status     = dropped_seen ? STATUS_DROPPED : STATUS_OK;
            expected_results = {expected_results, res};
         end
      end
      set_count    = 0;
      set_sum      = 0;
      dropped_seen = 1'b0;
   endtask

   always @(posedge clock) begin
      zresult_type want;
      if (reset) begin
         set_count    = 0;
         set_sum      = 0;
         dropped_seen = 1'b0;
         expected_results.delete();
         error_count  = 0;
         result_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected: zscore %0d", $signed(rsp_tdata));
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.zscore) begin
                  $error("zscore: expected %0d, got %0d", want.zscore, $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tlast !== want.end_of_set) begin
                  $error("end_of_set: expected %0b, got %0b", want.end_of_set, rsp_tlast);
                  error_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (set_count < MAX_SAMPLES) begin
               set_samples[set_count] = req_tdata;
               set_count++;
               set_sum += longint'($signed(req_tdata));
            end else begin
               dropped_seen = 1'b1;
            end
            if (req_tlast) predict_set();
         end
      end
   end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives sample sets of many sizes and value spreads into the z-score
// normalizer with random gaps and output stalls; the scoreboard judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;
   import zsn_pkg::*;

   localparam int MAX_SAMPLES = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TARGET_ITEMS = 380;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   sample_type req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;
   logic       rsp_tlast;
   status_type rsp_tuser;

   int  error_count, pending_count, result_count;
   int  cycle_count = 0;
   int  samples_sent = 0;
   int  sets_sent = 0;
   int  overflow_sets = 0;
   bit  hold_output = 1'b0;
   bit  no_idle = 1'b0;
   int  stall_left = 0;

   always #4 clock = ~clock;

   zscore_normalizer_top #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser
   );

   zsn_scoreboard #(.MAX_SAMPLES(MAX_SAMPLES)) u_scoreboard (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast, .rsp_tuser,
      .error_count, .pending_count, .result_count
   );

   function automatic int gap_length();
      if (no_idle) return 0;
      case ($urandom_range(0, 9))
         0, 1, 2:  return $urandom_range(1, 3);
         3:        return $urandom_range(10, 40);
         default:  return 0;
      endcase
   endfunction

   // Receiver: random stalls, plus a long hold-off when asked.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_output) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = gap_length();
         rsp_tready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_sample(sample_type value, logic last_flag);
      int idle;
      idle = gap_length();
      if (idle > 0) begin
         req_tvalid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tlast  = last_flag;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      samples_sent++;
      if (last_flag) sets_sent++;
   endtask

   task automatic send_set(sample_type values[$]);
      for (int i = 0; i < values.size(); i++)
         send_sample(values[i], i == values.size() - 1);
      if (values.size() > MAX_SAMPLES) overflow_sets++;
   endtask

   // Counted in cycles so that the block fills and stops taking samples.
   task automatic long_hold();
      hold_output = 1'b1;
      repeat (1500) @(posedge clock);
      hold_output = 1'b0;
   endtask

   initial begin
      sample_type vals[$];
      int size, spread, style;
      sample_type base;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A lone sample has zero deviation.
      vals = '{16'sh1234};                     send_set(vals);
      vals = '{-16'sd32768, 16'sd32767};       send_set(vals);
      vals = '{16'sd500, 16'sd500, 16'sd500};  send_set(vals);
      vals = '{16'sd0, 16'sd1};                send_set(vals);
      vals = '{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767};
      send_set(vals);
      // One far outlier among equal zeros; no result comes near saturation.
      vals = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767};
      send_set(vals);
      vals = '{16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00};
      send_set(vals);

      fork
         long_hold();
      join_none

      while (samples_sent < TARGET_ITEMS) begin
         vals.delete();
         no_idle = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 19))
            0:             size = $urandom_range(65, 70);
            1, 2, 3:       size = $urandom_range(17, 64);
            default:       size = $urandom_range(1, 16);
         endcase
         style  = $urandom_range(0, 9);
         base   = sample_type'($urandom);
         spread = $urandom_range(1, 300);
         for (int i = 0; i < size; i++) begin
            if (style == 0)
               vals = {vals, base};                      // flat set
            else if (style < 4)
               vals = {vals, sample_type'(base + sample_type'($urandom_range(0, spread)))};
            else if (style == 4)
               vals = {vals, ($urandom_range(0, 1) != 0) ? -16'sd32768 : 16'sd32767};
            else
               vals = {vals, sample_type'($urandom)};
         end
         send_set(vals);
      end
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
      no_idle    = 1'b0;

      wait (pending_count == 0 && !hold_output);
      repeat (100) @(posedge clock);

      $display("Covered %0d samples in %0d sets (%0d with dropped samples), %0d results.",
               samples_sent, sets_sent, overflow_sets, result_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
